// ----- src/mips_instruction_mix_profiler_top_assert.svh -----
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef MIPS_INSTRUCTION_MIX_PROFILER_TOP_ASSERT_SVH
`define MIPS_INSTRUCTION_MIX_PROFILER_TOP_ASSERT_SVH

// same-cycle implication
`define MIPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MIPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mipc_pkg.sv -----
package mipc_pkg;

  localparam int DEF_COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam int N_TYPES = 3;
  localparam int N_OPC   = 64;
  localparam int N_FUNCT = 64;
  localparam int N_REGS  = 32;

  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;

  localparam logic [2:0] TBL_TYPE      = 3'd0;
  localparam logic [2:0] TBL_OPCODE    = 3'd1;
  localparam logic [2:0] TBL_FUNCT     = 3'd2;
  localparam logic [2:0] TBL_REG_TOTAL = 3'd3;
  localparam logic [2:0] TBL_REG_RTYPE = 3'd4;
  localparam logic [2:0] TBL_REG_ITYPE = 3'd5;
  localparam logic [2:0] TBL_INSTR     = 3'd6;

  localparam logic [1:0] TYPE_R = 2'd0;
  localparam logic [1:0] TYPE_I = 2'd1;
  localparam logic [1:0] TYPE_J = 2'd2;

  localparam logic OP_RECORD = 1'b0;

  typedef struct packed {
    logic        op;
    logic [31:0] instr_word;
    logic [2:0]  read_table;
    logic [5:0]  read_index;
  } mipc_in_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic        bad_index;
  } mipc_out_t;

  typedef enum logic [1:0] {
    JOB_R,
    JOB_I,
    JOB_J,
    JOB_READ
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [5:0] opc;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
    logic [5:0] fn;
    logic [2:0] tbl;
    logic [5:0] idx;
    logic       bad;
  } job_t;

  typedef enum logic [1:0] {
    STEP_RS,
    STEP_RT,
    STEP_RD
  } step_t;

endpackage

// ----- src/mipc_front.sv -----
module mipc_front import mipc_pkg::*; (
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  mipc_in_t cmd,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [5:0] opc;
  logic       bad;

  assign opc       = cmd.instr_word[31:26];
  assign cmd_ready = !q_full;
  assign q_push    = cmd_valid && !q_full;

  always_comb begin
    case (cmd.read_table)
      TBL_TYPE:                                    bad = cmd.read_index >= 6'(N_TYPES);
      TBL_OPCODE, TBL_FUNCT:                       bad = 1'b0;
      TBL_REG_TOTAL, TBL_REG_RTYPE, TBL_REG_ITYPE: bad = cmd.read_index[5];
      TBL_INSTR:                                   bad = cmd.read_index != 6'd0;
      default:                                     bad = 1'b1;
    endcase
  end

  always_comb begin
    q_job.opc = opc;
    q_job.rs  = cmd.instr_word[25:21];
    q_job.rt  = cmd.instr_word[20:16];
    q_job.rd  = cmd.instr_word[15:11];
    q_job.fn  = cmd.instr_word[5:0];
    q_job.tbl = cmd.read_table;
    q_job.idx = cmd.read_index;
    q_job.bad = bad;
    if (cmd.op != OP_RECORD) begin
      q_job.kind = JOB_READ;
    end else if (opc == OPC_SPECIAL) begin
      q_job.kind = JOB_R;
    end else if (opc == OPC_J || opc == OPC_JAL) begin
      q_job.kind = JOB_J;
    end else begin
      q_job.kind = JOB_I;
    end
  end

endmodule

// ----- src/mipc_queue.sv -----
module mipc_queue import mipc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  job_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full       = count == CNTW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- src/mipc_cnt_ram.sv -----
module mipc_cnt_ram import mipc_pkg::*; #(
  parameter int DEPTH       = N_OPC,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                   inc,
  output logic [COUNT_WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld;
  logic [COUNT_WIDTH-1:0] mem_q;
  logic                   vld_q;
  logic [AW-1:0]          addr_q;
  logic                   lw_en;
  logic [AW-1:0]          lw_addr;
  logic [COUNT_WIDTH-1:0] lw_val;
  logic [COUNT_WIDTH-1:0] wdata;

  // bypass the write made in the same cycle as the read
  assign rd_data = (lw_en && lw_addr == addr_q) ? lw_val : (vld_q ? mem_q : '0);
  assign wdata   = rd_data + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      addr_q <= rd_addr;
    end
    if (inc) begin
      mem[addr_q] <= wdata;
    end
    lw_addr <= addr_q;
    lw_val  <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
      lw_en <= 1'b0;
    end else begin
      lw_en <= inc;
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
      if (inc) begin
        vld[addr_q] <= 1'b1;
      end
    end
  end

endmodule

// ----- src/mipc_back.sv -----
module mipc_back import mipc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_ready,
  output mipc_out_t res
);

  `include "mips_instruction_mix_profiler_top_assert.svh"

  localparam logic [COUNT_WIDTH-1:0] ONE = COUNT_WIDTH'(1);

  step_t step, step_next;

  logic [COUNT_WIDTH-1:0] instr_total;
  logic [COUNT_WIDTH-1:0] type_cnt [N_TYPES];

  logic       opc_en, fn_en, tot_en, rty_en, ity_en;
  logic [5:0] opc_addr, fn_addr;
  logic [4:0] tot_addr, rty_addr, ity_addr;
  logic       opc_inc_next, fn_inc_next, tot_inc_next, rty_inc_next, ity_inc_next;
  logic       opc_inc, fn_inc, tot_inc, rty_inc, ity_inc;
  logic [COUNT_WIDTH-1:0] opc_data, fn_data, tot_data, rty_data, ity_data;

  logic       bump_r, bump_i, bump_j;
  logic       issue_read;
  logic       rd_pend;
  logic [2:0] rd_tbl_q;
  logic       rd_bad_q;
  logic [COUNT_WIDTH-1:0] reg_val_q;
  logic [COUNT_WIDTH-1:0] reg_val_next;
  logic [COUNT_WIDTH-1:0] sel_val;
  logic [COUNT_WIDTH+31:0] sel_ext;

  always_comb begin
    step_next = step;
    pop       = 1'b0;
    opc_en = 1'b0; fn_en = 1'b0; tot_en = 1'b0; rty_en = 1'b0; ity_en = 1'b0;
    opc_addr = head.opc;
    fn_addr  = head.fn;
    tot_addr = head.rs;
    rty_addr = head.rs;
    ity_addr = head.rs;
    opc_inc_next = 1'b0; fn_inc_next = 1'b0; tot_inc_next = 1'b0;
    rty_inc_next = 1'b0; ity_inc_next = 1'b0;
    bump_r = 1'b0; bump_i = 1'b0; bump_j = 1'b0;
    issue_read = 1'b0;
    if (head_valid) begin
      case (head.kind)
        JOB_R: begin
          tot_en = 1'b1; rty_en = 1'b1;
          tot_inc_next = 1'b1; rty_inc_next = 1'b1;
          case (step)
            STEP_RS: begin
              opc_en = 1'b1; fn_en = 1'b1;
              opc_inc_next = 1'b1; fn_inc_next = 1'b1;
              bump_r    = 1'b1;
              step_next = STEP_RT;
            end
            STEP_RT: begin
              tot_addr  = head.rt;
              rty_addr  = head.rt;
              step_next = STEP_RD;
            end
            default: begin
              tot_addr  = head.rd;
              rty_addr  = head.rd;
              pop       = 1'b1;
              step_next = STEP_RS;
            end
          endcase
        end
        JOB_I: begin
          tot_en = 1'b1; ity_en = 1'b1;
          tot_inc_next = 1'b1; ity_inc_next = 1'b1;
          case (step)
            STEP_RS: begin
              opc_en       = 1'b1;
              opc_inc_next = 1'b1;
              bump_i       = 1'b1;
              step_next    = STEP_RT;
            end
            default: begin
              tot_addr  = head.rt;
              ity_addr  = head.rt;
              pop       = 1'b1;
              step_next = STEP_RS;
            end
          endcase
        end
        JOB_J: begin
          opc_en       = 1'b1;
          opc_inc_next = 1'b1;
          bump_j       = 1'b1;
          pop          = 1'b1;
        end
        default: begin
          if (!rd_pend && (!res_valid || res_ready)) begin
            issue_read = 1'b1;
            pop        = 1'b1;
            opc_addr   = head.idx;
            fn_addr    = head.idx;
            tot_addr   = head.idx[4:0];
            rty_addr   = head.idx[4:0];
            ity_addr   = head.idx[4:0];
            opc_en     = head.tbl == TBL_OPCODE;
            fn_en      = head.tbl == TBL_FUNCT;
            tot_en     = head.tbl == TBL_REG_TOTAL;
            rty_en     = head.tbl == TBL_REG_RTYPE;
            ity_en     = head.tbl == TBL_REG_ITYPE;
          end
        end
      endcase
    end
  end

  always_comb begin
    case (head.tbl)
      TBL_TYPE: begin
        case (head.idx[1:0])
          TYPE_R:  reg_val_next = type_cnt[TYPE_R];
          TYPE_I:  reg_val_next = type_cnt[TYPE_I];
          TYPE_J:  reg_val_next = type_cnt[TYPE_J];
          default: reg_val_next = '0;
        endcase
      end
      TBL_INSTR: reg_val_next = instr_total;
      default:   reg_val_next = '0;
    endcase
  end

  always_comb begin
    case (rd_tbl_q)
      TBL_TYPE, TBL_INSTR: sel_val = reg_val_q;
      TBL_OPCODE:          sel_val = opc_data;
      TBL_FUNCT:           sel_val = fn_data;
      TBL_REG_TOTAL:       sel_val = tot_data;
      TBL_REG_RTYPE:       sel_val = rty_data;
      TBL_REG_ITYPE:       sel_val = ity_data;
      default:             sel_val = '0;
    endcase
    sel_ext = {32'd0, sel_val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_RS;
      instr_total <= '0;
      for (int i = 0; i < N_TYPES; i++) begin
        type_cnt[i] <= '0;
      end
      opc_inc <= 1'b0; fn_inc <= 1'b0; tot_inc <= 1'b0;
      rty_inc <= 1'b0; ity_inc <= 1'b0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      step    <= step_next;
      opc_inc <= opc_inc_next;
      fn_inc  <= fn_inc_next;
      tot_inc <= tot_inc_next;
      rty_inc <= rty_inc_next;
      ity_inc <= ity_inc_next;
      if (bump_r || bump_i || bump_j) begin
        instr_total <= instr_total + ONE;
      end
      if (bump_r) begin
        type_cnt[TYPE_R] <= type_cnt[TYPE_R] + ONE;
      end
      if (bump_i) begin
        type_cnt[TYPE_I] <= type_cnt[TYPE_I] + ONE;
      end
      if (bump_j) begin
        type_cnt[TYPE_J] <= type_cnt[TYPE_J] + ONE;
      end
      rd_pend <= issue_read;
      if (rd_pend) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_read) begin
      rd_tbl_q  <= head.tbl;
      rd_bad_q  <= head.bad;
      reg_val_q <= reg_val_next;
    end
    if (rd_pend) begin
      res.count_value <= rd_bad_q ? 32'd0 : sel_ext[31:0];
      res.bad_index   <= rd_bad_q;
    end
  end

  mipc_cnt_ram #(.DEPTH(N_OPC), .COUNT_WIDTH(COUNT_WIDTH)) u_opc_ram (
    .clk(clk), .rst(rst), .rd_en(opc_en), .rd_addr(opc_addr), .inc(opc_inc),
    .rd_data(opc_data)
  );

  mipc_cnt_ram #(.DEPTH(N_FUNCT), .COUNT_WIDTH(COUNT_WIDTH)) u_fn_ram (
    .clk(clk), .rst(rst), .rd_en(fn_en), .rd_addr(fn_addr), .inc(fn_inc),
    .rd_data(fn_data)
  );

  mipc_cnt_ram #(.DEPTH(N_REGS), .COUNT_WIDTH(COUNT_WIDTH)) u_tot_ram (
    .clk(clk), .rst(rst), .rd_en(tot_en), .rd_addr(tot_addr), .inc(tot_inc),
    .rd_data(tot_data)
  );

  mipc_cnt_ram #(.DEPTH(N_REGS), .COUNT_WIDTH(COUNT_WIDTH)) u_rty_ram (
    .clk(clk), .rst(rst), .rd_en(rty_en), .rd_addr(rty_addr), .inc(rty_inc),
    .rd_data(rty_data)
  );

  mipc_cnt_ram #(.DEPTH(N_REGS), .COUNT_WIDTH(COUNT_WIDTH)) u_ity_ram (
    .clk(clk), .rst(rst), .rd_en(ity_en), .rd_addr(ity_addr), .inc(ity_inc),
    .rd_data(ity_data)
  );

  `MIPC_ASSERT_NEXT(a_pend_loads_res, rd_pend, res_valid, "read data not loaded")
  `MIPC_ASSERT_NEXT(a_pend_single, rd_pend, !rd_pend, "back-to-back read issue")
  `MIPC_ASSERT_IMPL(a_step_idle, !head_valid, step == STEP_RS, "step left mid-job")

endmodule

// ----- src/mips_instruction_mix_profiler_top.sv -----
// Read path: res_valid rises after a read beat accepted into an idle back end is issued
// and registered in rd_pend. Records take one register field per cycle (rs, rt, rd for
// R-type; rs, rt for I-type), set by the single read/increment port of the
// register-count RAMs. Reset: synchronous, active high; every counter reads zero right
// after reset, the RAM counters through per-entry valid bits, with no clearing pass.
module mips_instruction_mix_profiler_top import mipc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  mipc_in_t  cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output mipc_out_t res
);

  logic q_full;
  logic q_push;
  job_t q_job;
  logic q_pop;
  logic q_head_valid;
  job_t q_head;

  mipc_front u_front (
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(q_job)
  );

  mipc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(q_job),
    .full(q_full),
    .pop(q_pop),
    .head_valid(q_head_valid),
    .head(q_head)
  );

  mipc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(q_head_valid),
    .head(q_head),
    .pop(q_pop),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

endmodule
